// ===== hw/rtl/mrle_pkg.sv =====
// Shared types, constants and the run encoding function of the marker
// run-length byte encoder. No dependencies; imported by every module.
package mrle_pkg;

    localparam int unsigned COUNT_W          = 17;
    localparam int unsigned BUF_MAX          = 7;
    localparam int unsigned QUEUE_DEPTH_DEF  = 4;

    localparam logic [COUNT_W-1:0] RUN_CAP    = 17'd66303;
    localparam logic [COUNT_W-1:0] LONG_BASE  = 17'd768;
    localparam logic [COUNT_W-1:0] MID_BASE   = 17'd256;
    localparam logic [COUNT_W-1:0] SHORT_MIN  = 17'd4;

    localparam logic [7:0] MARKER_RESET = 8'hC3;
    localparam logic [7:0] LONG_TAG     = 8'h03;
    localparam logic [7:0] ESC_BYTE     = 8'h00;

    localparam logic [2:0] LEN_SHORT    = 3'd3;
    localparam logic [2:0] LEN_MID      = 3'd4;
    localparam logic [2:0] LEN_LONG     = 3'd5;

    typedef logic [2:0] len_t;

    // One closed-run command; run A is the run closed by a value change,
    // run B the run closed by the cap or the end of the stream.
    typedef struct packed {
        logic               a_valid;
        logic [7:0]         a_value;
        logic [COUNT_W-1:0] a_count;
        logic               b_valid;
        logic [7:0]         b_value;
        logic [COUNT_W-1:0] b_count;
        logic               last;
        logic [7:0]         marker;
    } run_cmd_t;

    typedef struct packed {
        logic [BUF_MAX-1:0][7:0] bytes;
        len_t                    len;
    } run_code_t;

    // Encoded bytes of one run, first byte in bytes[0].
    function automatic run_code_t encode_run(input logic [7:0]         value,
                                             input logic [COUNT_W-1:0] count,
                                             input logic [7:0]         marker);
        run_code_t          code;
        logic [COUNT_W-1:0] diff;
        logic               esc;
        code.bytes = '0;
        code.len   = '0;
        diff       = count - LONG_BASE;
        esc        = (value == marker);
        if (count < SHORT_MIN)
        begin
            // literal copies; a copy equal to the marker takes an escape byte
            for (int i = 0; i < 3; i++)
            begin
                if (esc)
                begin
                    code.bytes[2*i]   = value;
                    code.bytes[2*i+1] = ESC_BYTE;
                end
                else
                begin
                    code.bytes[i] = value;
                end
            end
            code.len = esc ? {count[1:0], 1'b0} : {1'b0, count[1:0]};
        end
        else if (count >= LONG_BASE)
        begin
            code.bytes[0] = marker;
            code.bytes[1] = LONG_TAG;
            code.bytes[2] = diff[15:8];
            code.bytes[3] = diff[7:0];
            code.bytes[4] = value;
            code.len      = LEN_LONG;
        end
        else if (count >= MID_BASE)
        begin
            code.bytes[0] = marker;
            code.bytes[1] = {6'b0, count[9:8]};
            code.bytes[2] = count[7:0];
            code.bytes[3] = value;
            code.len      = LEN_MID;
        end
        else
        begin
            code.bytes[0] = marker;
            code.bytes[1] = count[7:0];
            code.bytes[2] = value;
            code.len      = LEN_SHORT;
        end
        return code;
    endfunction

endpackage

// ===== hw/rtl/mrle_front.sv =====
// Front end: tracks the open run and emits closed-run commands.
// Depends on mrle_pkg.
module mrle_front
    import mrle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic [7:0] marker,
    input  logic       q_full,
    output logic       push,
    output run_cmd_t   push_cmd
);

    logic [7:0]         run_value_reg;
    logic [7:0]         run_value_next;
    logic [COUNT_W-1:0] run_count_reg;
    logic [COUNT_W-1:0] run_count_next;
    logic [COUNT_W-1:0] new_count;
    logic               close_prev;
    logic               close_cur;
    logic               accept;

    assign in_ready = ~q_full;
    assign accept   = in_valid & in_ready;

    always_comb
    begin
        close_prev = (run_count_reg != '0) && (in_byte != run_value_reg);
        if ((run_count_reg == '0) || close_prev)
            new_count = COUNT_W'(1);
        else
            new_count = run_count_reg + COUNT_W'(1);
        close_cur = (new_count == RUN_CAP) || in_last;

        push_cmd.a_valid = close_prev;
        push_cmd.a_value = run_value_reg;
        push_cmd.a_count = run_count_reg;
        push_cmd.b_valid = close_cur;
        push_cmd.b_value = in_byte;
        push_cmd.b_count = new_count;
        push_cmd.last    = in_last;
        push_cmd.marker  = marker;

        push = accept & (close_prev | close_cur);

        run_value_next = run_value_reg;
        run_count_next = run_count_reg;
        if (accept)
        begin
            run_value_next = in_byte;
            run_count_next = close_cur ? '0 : new_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_value_reg <= '0;
            run_count_reg <= '0;
        end
        else
        begin
            run_value_reg <= run_value_next;
            run_count_reg <= run_count_next;
        end
    end

endmodule

// ===== hw/rtl/mrle_cmd_queue.sv =====
// Short command queue between front and back end.
// Depends on mrle_pkg for the command type.
module mrle_cmd_queue
    import mrle_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  run_cmd_t push_cmd,
    output logic     full,
    input  logic     pop,
    output logic     head_valid,
    output run_cmd_t head_cmd
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    run_cmd_t         entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;

    assign full       = (fill_reg == CNT_W'(DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            fill_next = fill_reg + CNT_W'(1);
        else if (pop && !push)
            fill_next = fill_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// ===== hw/rtl/mrle_back.sv =====
// Back end: expands one queued command into encoded bytes and shifts them out.
// Depends on mrle_pkg (encode_run, command type).
module mrle_back
    import mrle_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     head_valid,
    input  run_cmd_t head_cmd,
    output logic     pop,
    output logic     out_valid,
    input  logic     out_ready,
    output logic [7:0] out_byte,
    output logic     out_group_end,
    output logic     out_stream_end
);

    logic [BUF_MAX-1:0][7:0] buf_reg;
    logic [BUF_MAX-1:0][7:0] buf_next;
    len_t                    len_reg;
    len_t                    len_next;
    logic                    last_reg;
    logic                    last_next;
    logic [BUF_MAX-1:0][7:0] merged;
    run_code_t               code_a;
    run_code_t               code_b;
    len_t                    len_a;
    len_t                    len_b;
    logic [3:0]              len_sum;
    len_t                    b_idx;
    logic                    transfer;

    assign out_valid      = (len_reg != '0);
    assign out_byte       = buf_reg[0];
    assign out_group_end  = (len_reg == len_t'(1));
    assign out_stream_end = (len_reg == len_t'(1)) & last_reg;
    assign transfer       = out_valid & out_ready;
    assign pop            = head_valid & ((len_reg == '0) | ((len_reg == len_t'(1)) & out_ready));

    always_comb
    begin
        code_a  = encode_run(head_cmd.a_value, head_cmd.a_count, head_cmd.marker);
        code_b  = encode_run(head_cmd.b_value, head_cmd.b_count, head_cmd.marker);
        len_a   = head_cmd.a_valid ? code_a.len : '0;
        len_b   = head_cmd.b_valid ? code_b.len : '0;
        len_sum = {1'b0, len_a} + {1'b0, len_b};
        b_idx   = '0;
        // run A first, run B packed right behind it
        for (int i = 0; i < BUF_MAX; i++)
        begin
            b_idx = len_t'(i) - len_a;
            if (len_t'(i) < len_a)
                merged[i] = code_a.bytes[i];
            else
                merged[i] = code_b.bytes[b_idx];
        end

        buf_next  = buf_reg;
        len_next  = len_reg;
        last_next = last_reg;
        if (pop)
        begin
            buf_next  = merged;
            len_next  = len_sum[2:0];
            last_next = head_cmd.last;
        end
        else if (transfer)
        begin
            buf_next = buf_reg >> 8;
            len_next = len_reg - len_t'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg  <= buf_next;
        last_reg <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            len_reg <= '0;
        else
            len_reg <= len_next;
    end

endmodule

// ===== hw/rtl/marker_rle_byte_encoder_core.sv =====
// Top level of the marker run-length byte encoder.
// Depends on mrle_pkg, mrle_front, mrle_cmd_queue and mrle_back.
//
// The encoder takes one raw byte per cycle on the s_ side and sends the
// encoded stream one byte per cycle on the m_ side while m_tready is high.
// A run of equal bytes is held open until a different byte arrives, the
// count reaches 66303, or a byte with s_tlast is taken; it is then sent as
// literals (runs of 1 to 3, with a 0 after every literal equal to the
// marker) or as a marker sequence (marker, count / marker, high, low /
// marker, 3, high, low of count - 768, then the value). The input side
// takes a byte every cycle while the command queue (QUEUE_DEPTH entries)
// has room; a byte that closes runs produces 1 to 7 bytes on the output
// side, one per transfer, so the sustained rate is set by the single-byte
// output port. Bytes are registered in the command queue, then the back-end
// buffer. m_tuser flags the last byte caused by one input byte and m_tlast
// the final byte of the stream. The marker register resets to 0xC3; the
// user must write it through the cfg port only while no run is being
// encoded (the block does not check); a run uses the marker set at close.
module marker_rle_byte_encoder_core
    import mrle_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    // input stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] data_byte
    input  logic       s_tlast,    // last_in
    // encoded stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] out_byte
    output logic [0:0] m_tuser,    // [0] group_end
    output logic       m_tlast,    // stream_end
    // marker register write
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data    // [7:0] marker_code
);

    logic [7:0] marker_reg;
    logic       q_full;
    logic       q_push;
    run_cmd_t   q_push_cmd;
    logic       q_pop;
    logic       q_head_valid;
    run_cmd_t   q_head_cmd;
    logic       group_end;

    // take a marker write on every cycle
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            marker_reg <= MARKER_RESET;
        else if (cfg_valid)
            marker_reg <= cfg_data;
    end

    // track the open run, issue a command for every input that closes one
    mrle_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .marker   (marker_reg),
        .q_full   (q_full),
        .push     (q_push),
        .push_cmd (q_push_cmd)
    );

    // decouple run tracking from byte output
    mrle_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd)
    );

    // expand commands into encoded bytes, one per output transfer
    mrle_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (q_head_valid),
        .head_cmd       (q_head_cmd),
        .pop            (q_pop),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_byte       (m_tdata),
        .out_group_end  (group_end),
        .out_stream_end (m_tlast)
    );

    assign m_tuser[0] = group_end;

endmodule
